// ===== hw/rtl/stack_vm_instruction_executor_top_assert.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the stack machine executor
// Implication checks used at the end of the top level.
// ----------------------------------------------------------------------------
`ifndef STACK_VM_INSTRUCTION_EXECUTOR_TOP_ASSERT_SVH
`define STACK_VM_INSTRUCTION_EXECUTOR_TOP_ASSERT_SVH

// Same-cycle implication.
`define SVIE_ASSERT_NOW(name, clk, rst, pre, post, msg) \
   name: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
      else $error(msg);

// Next-cycle implication.
`define SVIE_ASSERT_NEXT(name, clk, rst, pre, post, msg) \
   name: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
      else $error(msg);

`endif

// ===== hw/rtl/svie_pkg.sv =====
// ----------------------------------------------------------------------------
// Stack machine executor package
// Opcodes, status codes, controller states and command/status bundles.
// ----------------------------------------------------------------------------
package svie_pkg;

   localparam logic [4:0] OP_ALLOC  = 5'd0;
   localparam logic [4:0] OP_PUSH   = 5'd1;
   localparam logic [4:0] OP_POP    = 5'd2;
   localparam logic [4:0] OP_ADD    = 5'd3;
   localparam logic [4:0] OP_SUB    = 5'd4;
   localparam logic [4:0] OP_MUL    = 5'd5;
   localparam logic [4:0] OP_DIV    = 5'd6;
   localparam logic [4:0] OP_INCR   = 5'd7;
   localparam logic [4:0] OP_DECR   = 5'd8;
   localparam logic [4:0] OP_LOAD   = 5'd9;
   localparam logic [4:0] OP_LOAD8  = 5'd10;
   localparam logic [4:0] OP_STORE  = 5'd11;
   localparam logic [4:0] OP_STORE8 = 5'd12;
   localparam logic [4:0] OP_GOTO   = 5'd13;
   localparam logic [4:0] OP_CALL   = 5'd14;
   localparam logic [4:0] OP_RETURN = 5'd15;
   localparam logic [4:0] OP_ENTER  = 5'd16;
   localparam logic [4:0] OP_LEAVE  = 5'd17;
   localparam logic [4:0] OP_JUMPZ  = 5'd18;
   localparam logic [4:0] OP_JUMPNZ = 5'd19;
   localparam logic [4:0] OP_DUP    = 5'd20;
   localparam logic [4:0] OP_HALT   = 5'd21;
   localparam logic [4:0] OP_LABEL  = 5'd22;
   localparam logic [4:0] OP_NOOP   = 5'd23;

   localparam logic [1:0] PT_NONE = 2'd0;
   localparam logic [1:0] PT_IMM  = 2'd1;
   localparam logic [1:0] PT_REG  = 2'd2;

   localparam logic [1:0] REG_SP = 2'd0;
   localparam logic [1:0] REG_IP = 2'd1;
   localparam logic [1:0] REG_FP = 2'd2;

   localparam logic [2:0] ST_OK       = 3'd0;
   localparam logic [2:0] ST_HALTED   = 3'd1;
   localparam logic [2:0] ST_BAD_MEM  = 3'd2;
   localparam logic [2:0] ST_BAD_SIZE = 3'd3;
   localparam logic [2:0] ST_ILLEGAL  = 3'd4;
   localparam logic [2:0] ST_DIV_ZERO = 3'd5;

   localparam logic [31:0] BYTE_MASK = 32'h0000_00ff;

   typedef enum logic [3:0] {
      S_CLEAR, S_IDLE, S_READ, S_CAPTURE, S_EXEC,
      S_DIVIDE, S_DIVFIX, S_WRITE, S_ALLOC, S_FINISH
   } svie_state_type;

   typedef struct packed {
      logic       load;
      logic       clear_wr;
      logic       rd_issue;
      logic       rd_capture;
      logic [1:0] idx;
      logic       exec;
      logic       div_step;
      logic       div_fix;
      logic       wr_en;
      logic       alloc_wr;
      logic       finish;
   } svie_cmd_type;

   typedef struct packed {
      logic [1:0] rd_count;
      logic [1:0] wr_count;
      logic       fault;
      logic       is_div;
      logic       div_last;
      logic       alloc_any;
      logic       alloc_last;
      logic       clear_last;
   } svie_stat_type;

   function automatic logic [1:0] num_reads(input logic [4:0] kind);
      logic [1:0] n;
      case (kind)
         OP_ADD, OP_SUB, OP_MUL, OP_DIV, OP_LOAD, OP_LOAD8, OP_STORE: n = 2'd2;
         OP_STORE8, OP_RETURN:                                    n = 2'd3;
         OP_POP, OP_INCR, OP_DECR, OP_JUMPZ, OP_JUMPNZ, OP_DUP,
         OP_LEAVE:                                                n = 2'd1;
         default:                                                 n = 2'd0;
      endcase
      return n;
   endfunction

   function automatic logic [1:0] num_writes(input logic [4:0] kind);
      logic [1:0] n;
      case (kind)
         OP_PUSH, OP_ADD, OP_SUB, OP_MUL, OP_DIV, OP_INCR, OP_DECR, OP_LOAD,
         OP_LOAD8, OP_STORE, OP_STORE8, OP_ENTER, OP_DUP: n = 2'd1;
         OP_CALL:                                         n = 2'd3;
         default:                                         n = 2'd0;
      endcase
      return n;
   endfunction

endpackage

// ===== hw/rtl/svie_req_if.sv =====
// ----------------------------------------------------------------------------
// Instruction channel
// Valid/ready channel that carries one instruction per transaction.
// ----------------------------------------------------------------------------
interface svie_req_if;
   logic        valid;
   logic        ready;
   logic [4:0]  kind;
   logic [1:0]  param_type;
   logic signed [31:0] param_value;
   logic [1:0]  reg_select;

   modport source (output valid, kind, param_type, param_value, reg_select, input ready);
   modport sink   (input valid, kind, param_type, param_value, reg_select, output ready);
endinterface

// ===== hw/rtl/svie_rsp_if.sv =====
// ----------------------------------------------------------------------------
// Result channel
// Valid/ready channel that carries status and pointers per transaction.
// ----------------------------------------------------------------------------
interface svie_rsp_if;
   logic        valid;
   logic        ready;
   logic [2:0]  status;
   logic signed [31:0] next_ip;
   logic signed [31:0] stack_ptr_out;
   logic signed [31:0] frame_ptr_out;

   modport source (output valid, status, next_ip, stack_ptr_out, frame_ptr_out, input ready);
   modport sink   (input valid, status, next_ip, stack_ptr_out, frame_ptr_out, output ready);
endinterface

// ===== hw/rtl/stack_vm_instruction_executor_top.sv =====
// ----------------------------------------------------------------------------
// Stack machine instruction executor
// DIV adds a serial divide and ALLOC adds a pass that zeroes each newly allocated word.
// Throughput: one instruction at a time, set by the single memory port and the serial divider.
// Reset: synchronous; a clearing pass zeroes all MEM_BYTES/4 words of memory, no accept meanwhile.
// ----------------------------------------------------------------------------
module stack_vm_instruction_executor_top #(
   parameter int MEM_BYTES = 2048
) (
   input  logic        clock,
   input  logic        reset,
   svie_req_if.sink    req_chan,
   svie_rsp_if.source  rsp_chan
);

   // The controller sequences each instruction: it reads up to three operand
   // words from memory, one at a time through S_READ and S_CAPTURE, then lets
   // the datapath check bounds and compute the new pointers in S_EXEC.
   svie_pkg::svie_cmd_type  cmd;
   svie_pkg::svie_stat_type stat;

   svie_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_chan.ready),
      .rsp_valid (rsp_chan.valid),
      .rsp_ready (rsp_chan.ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   // The datapath holds the word memory, the pointers and the result register.
   // Pointers are committed only when the result transaction is loaded, so a
   // faulting instruction leaves the memory and the pointers as they were.
   svie_dpath #(
      .MEM_BYTES (MEM_BYTES)
   ) u_dpath (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .stat              (stat),
      .req_kind          (req_chan.kind),
      .req_param_type    (req_chan.param_type),
      .req_param_value   (req_chan.param_value),
      .req_reg_select    (req_chan.reg_select),
      .rsp_status        (rsp_chan.status),
      .rsp_next_ip       (rsp_chan.next_ip),
      .rsp_stack_ptr_out (rsp_chan.stack_ptr_out),
      .rsp_frame_ptr_out (rsp_chan.frame_ptr_out)
   );

`include "stack_vm_instruction_executor_top_assert.svh"

   // After an accepted instruction the block is busy until its result is loaded.
   `SVIE_ASSERT_NEXT(a_busy_after_accept, clock, reset, req_chan.valid && req_chan.ready, !req_chan.ready, "instruction accepted while busy")
   // Loading a result always leaves a valid transaction on the result channel.
   `SVIE_ASSERT_NEXT(a_rsp_after_finish, clock, reset, cmd.finish, rsp_chan.valid, "result lost")
   // No instruction is taken while memory is still being cleared.
   `SVIE_ASSERT_NOW(a_no_accept_clear, clock, reset, cmd.clear_wr, !req_chan.ready, "accept during clear")
   // A result is never overwritten while the sink still holds it off.
   `SVIE_ASSERT_NOW(a_no_overwrite, clock, reset, cmd.finish && rsp_chan.valid, rsp_chan.ready, "result overwritten")

endmodule

// ===== hw/rtl/svie_ctrl.sv =====
// ----------------------------------------------------------------------------
// Stack machine executor controller
// Sequences memory clear, reads, execution, divide, writes, ALLOC zeroing and result hand-off.
// ----------------------------------------------------------------------------
module svie_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   input  svie_pkg::svie_stat_type stat,
   output svie_pkg::svie_cmd_type  cmd
);

   svie_pkg::svie_state_type state_ff, state_in;
   logic [1:0] idx_ff, idx_in;
   logic       rsp_valid_ff, rsp_valid_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= svie_pkg::S_CLEAR;
         idx_ff       <= 2'd0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         idx_ff       <= idx_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_comb begin
      state_in     = state_ff;
      idx_in       = idx_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      req_ready    = 1'b0;
      cmd          = '0;
      cmd.idx      = idx_ff;
      case (state_ff)
         svie_pkg::S_CLEAR: begin
            cmd.clear_wr = 1'b1;
            if (stat.clear_last) state_in = svie_pkg::S_IDLE;
         end
         svie_pkg::S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.load = 1'b1;
               idx_in   = 2'd0;
               state_in = svie_pkg::S_READ;
            end
         end
         svie_pkg::S_READ: begin
            if (idx_ff == stat.rd_count) begin
               state_in = svie_pkg::S_EXEC;
            end else begin
               cmd.rd_issue = 1'b1;
               state_in     = svie_pkg::S_CAPTURE;
            end
         end
         svie_pkg::S_CAPTURE: begin
            cmd.rd_capture = 1'b1;
            idx_in         = idx_ff + 2'd1;
            state_in       = svie_pkg::S_READ;
         end
         svie_pkg::S_EXEC: begin
            cmd.exec = 1'b1;
            idx_in   = 2'd0;
            if (stat.fault)                state_in = svie_pkg::S_FINISH;
            else if (stat.is_div)          state_in = svie_pkg::S_DIVIDE;
            else if (stat.alloc_any)       state_in = svie_pkg::S_ALLOC;
            else if (stat.wr_count != 2'd0) state_in = svie_pkg::S_WRITE;
            else                           state_in = svie_pkg::S_FINISH;
         end
         svie_pkg::S_DIVIDE: begin
            cmd.div_step = 1'b1;
            if (stat.div_last) state_in = svie_pkg::S_DIVFIX;
         end
         svie_pkg::S_DIVFIX: begin
            cmd.div_fix = 1'b1;
            state_in    = svie_pkg::S_WRITE;
         end
         svie_pkg::S_WRITE: begin
            cmd.wr_en = 1'b1;
            idx_in    = idx_ff + 2'd1;
            if (idx_ff + 2'd1 == stat.wr_count) state_in = svie_pkg::S_FINISH;
         end
         svie_pkg::S_ALLOC: begin
            cmd.alloc_wr = 1'b1;
            if (stat.alloc_last) state_in = svie_pkg::S_FINISH;
         end
         svie_pkg::S_FINISH: begin
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.finish   = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = svie_pkg::S_IDLE;
            end
         end
         default: state_in = svie_pkg::S_CLEAR;
      endcase
   end

   assign rsp_valid = rsp_valid_ff;

endmodule

// ===== hw/rtl/svie_dpath.sv =====
// ----------------------------------------------------------------------------
// Stack machine executor datapath
// Word memory, pointer registers, operand slots, ALU and serial divider.
// ----------------------------------------------------------------------------
module svie_dpath #(
   parameter int MEM_BYTES = 2048
) (
   input  logic                   clock,
   input  logic                   reset,
   input  svie_pkg::svie_cmd_type  cmd,
   output svie_pkg::svie_stat_type stat,
   input  logic [4:0]             req_kind,
   input  logic [1:0]             req_param_type,
   input  logic [31:0]            req_param_value,
   input  logic [1:0]             req_reg_select,
   output logic [2:0]             rsp_status,
   output logic [31:0]            rsp_next_ip,
   output logic [31:0]            rsp_stack_ptr_out,
   output logic [31:0]            rsp_frame_ptr_out
);

   localparam int Words     = MEM_BYTES / 4;
   localparam int ByteLimit = Words * 4;
   localparam int AW        = $clog2(Words);

   logic [31:0] mem [Words];

   logic [4:0]  kind_ff;
   logic [1:0]  ptype_ff, sel_ff;
   logic [31:0] pv_ff;
   logic [31:0] sp_ff, fp_ff, ip_ff;
   logic [31:0] rdata_ff, a_ff, b_ff, c_ff, r_ff;
   logic [2:0]  st_ff, st_in;
   logic [31:0] nsp_ff, nfp_ff, nip_ff, nsp_in, nfp_in, nip_in, r_in;
   logic [31:0] rem_ff, quo_ff, dvs_ff;
   logic        neg_ff;
   logic [4:0]  dcnt_ff;
   logic [AW-1:0] clr_ff, acnt_ff, aend_ff;
   logic [AW-1:0] rd_addr, wr_addr;
   logic [31:0] wr_data;
   logic [2:0]  rsp_status_ff;
   logic [31:0] rsp_ip_ff, rsp_sp_ff, rsp_fp_ff;

   logic [31:0] sm1, sm2, sp1, sp3, fm1, fm2, fm3, ipn, top, start, reg_v;
   logic        alloc_any;
   logic [4:0]  sh;
   logic [32:0] dsh;
   logic        dge;

   function automatic logic word_ok(input logic [31:0] x);
      return x < 32'(Words);
   endfunction

   assign sm1   = sp_ff - 32'd1;
   assign sm2   = sp_ff - 32'd2;
   assign sp1   = sp_ff + 32'd1;
   assign sp3   = sp_ff + 32'd3;
   assign fm1   = fp_ff - 32'd1;
   assign fm2   = fp_ff - 32'd2;
   assign fm3   = fp_ff - 32'd3;
   assign ipn   = ip_ff + 32'd1;
   assign top   = sp_ff + pv_ff;
   assign start = sp_ff[31] ? 32'd0 : sp_ff;
   assign sh    = {a_ff[1:0], 3'b000};

   always_comb begin
      case (sel_ff)
         svie_pkg::REG_SP: reg_v = sp_ff;
         svie_pkg::REG_IP: reg_v = ip_ff;
         default:          reg_v = fp_ff;
      endcase
   end

   // Read address for each operand slot.
   always_comb begin
      case (kind_ff)
         svie_pkg::OP_ADD, svie_pkg::OP_SUB, svie_pkg::OP_MUL, svie_pkg::OP_DIV:
            rd_addr = (cmd.idx == 2'd0) ? sm2[AW-1:0] : sm1[AW-1:0];
         svie_pkg::OP_LOAD:
            rd_addr = (cmd.idx == 2'd0) ? sm1[AW-1:0] : a_ff[AW-1:0];
         svie_pkg::OP_LOAD8:
            rd_addr = (cmd.idx == 2'd0) ? sm1[AW-1:0] : a_ff[AW+1:2];
         svie_pkg::OP_STORE, svie_pkg::OP_STORE8: begin
            case (cmd.idx)
               2'd0:    rd_addr = sm1[AW-1:0];
               2'd1:    rd_addr = sm2[AW-1:0];
               default: rd_addr = a_ff[AW+1:2];
            endcase
         end
         svie_pkg::OP_RETURN: begin
            case (cmd.idx)
               2'd0:    rd_addr = fm3[AW-1:0];
               2'd1:    rd_addr = fm2[AW-1:0];
               default: rd_addr = fm1[AW-1:0];
            endcase
         end
         svie_pkg::OP_LEAVE: rd_addr = fm1[AW-1:0];
         default:            rd_addr = sm1[AW-1:0];
      endcase
   end

   // Write address and data for each write step.
   always_comb begin
      wr_data = r_ff;
      case (kind_ff)
         svie_pkg::OP_ADD, svie_pkg::OP_SUB, svie_pkg::OP_MUL, svie_pkg::OP_DIV:
            wr_addr = sm2[AW-1:0];
         svie_pkg::OP_STORE:  wr_addr = a_ff[AW-1:0];
         svie_pkg::OP_STORE8: wr_addr = a_ff[AW+1:2];
         svie_pkg::OP_PUSH, svie_pkg::OP_ENTER, svie_pkg::OP_DUP:
            wr_addr = sp_ff[AW-1:0];
         svie_pkg::OP_CALL: begin
            wr_addr = sp_ff[AW-1:0] + AW'(cmd.idx);
            if (cmd.idx == 2'd1)      wr_data = fp_ff;
            else if (cmd.idx == 2'd2) wr_data = sp_ff;
         end
         default: wr_addr = sm1[AW-1:0];
      endcase
   end

   // Checks and next pointers from the captured operands.
   always_comb begin
      st_in     = svie_pkg::ST_OK;
      nsp_in    = sp_ff;
      nfp_in    = fp_ff;
      nip_in    = ip_ff;
      r_in      = 32'd0;
      alloc_any = 1'b0;
      case (kind_ff)
         svie_pkg::OP_ALLOC: begin
            if (!word_ok(top)) st_in = svie_pkg::ST_BAD_MEM;
            else begin
               nsp_in    = top;
               nip_in    = ipn;
               alloc_any = start < top;
            end
         end
         svie_pkg::OP_PUSH, svie_pkg::OP_ENTER: begin
            if (!word_ok(sp1) || !word_ok(sp_ff)) st_in = svie_pkg::ST_BAD_MEM;
            else if (kind_ff == svie_pkg::OP_ENTER) begin
               r_in = fp_ff; nfp_in = sp1; nsp_in = sp1; nip_in = ipn;
            end else if (ptype_ff == svie_pkg::PT_IMM) begin
               r_in = pv_ff; nsp_in = sp1; nip_in = ipn;
            end else if (ptype_ff == svie_pkg::PT_REG && sel_ff != 2'd3) begin
               r_in = reg_v; nsp_in = sp1; nip_in = ipn;
            end else st_in = svie_pkg::ST_ILLEGAL;
         end
         svie_pkg::OP_POP: begin
            if (!word_ok(sm1)) st_in = svie_pkg::ST_BAD_MEM;
            else begin
               case (ptype_ff)
                  svie_pkg::PT_NONE: begin nsp_in = sm1; nip_in = ipn; end
                  svie_pkg::PT_IMM:  begin nsp_in = sp_ff - pv_ff; nip_in = ipn; end
                  svie_pkg::PT_REG: begin
                     case (sel_ff)
                        svie_pkg::REG_SP: begin nsp_in = a_ff; nip_in = ipn; end
                        svie_pkg::REG_IP: begin nip_in = a_ff; nsp_in = sm1; end
                        svie_pkg::REG_FP: begin
                           nfp_in = a_ff; nsp_in = sm1; nip_in = ipn;
                        end
                        default: st_in = svie_pkg::ST_ILLEGAL;
                     endcase
                  end
                  default: st_in = svie_pkg::ST_ILLEGAL;
               endcase
            end
         end
         svie_pkg::OP_ADD, svie_pkg::OP_SUB, svie_pkg::OP_MUL, svie_pkg::OP_DIV: begin
            if (!word_ok(sm2) || !word_ok(sm1)) st_in = svie_pkg::ST_BAD_MEM;
            else if (kind_ff == svie_pkg::OP_DIV && b_ff == 32'd0)
               st_in = svie_pkg::ST_DIV_ZERO;
            else begin
               case (kind_ff)
                  svie_pkg::OP_ADD: r_in = a_ff + b_ff;
                  svie_pkg::OP_SUB: r_in = a_ff - b_ff;
                  svie_pkg::OP_MUL: r_in = a_ff * b_ff;
                  default:          r_in = 32'd0;
               endcase
               nsp_in = sm1; nip_in = ipn;
            end
         end
         svie_pkg::OP_INCR, svie_pkg::OP_DECR: begin
            if (!word_ok(sm1)) st_in = svie_pkg::ST_BAD_MEM;
            else begin
               r_in   = (kind_ff == svie_pkg::OP_INCR) ? a_ff + 32'd1 : a_ff - 32'd1;
               nip_in = ipn;
            end
         end
         svie_pkg::OP_LOAD: begin
            if (!word_ok(sm1) || !word_ok(a_ff)) st_in = svie_pkg::ST_BAD_MEM;
            else begin r_in = b_ff; nip_in = ipn; end
         end
         svie_pkg::OP_LOAD8: begin
            if (!word_ok(sm1) || a_ff >= 32'(ByteLimit)) st_in = svie_pkg::ST_BAD_MEM;
            else begin r_in = (b_ff >> sh) & svie_pkg::BYTE_MASK; nip_in = ipn; end
         end
         svie_pkg::OP_STORE: begin
            if (!word_ok(sm1) || !word_ok(a_ff) || !word_ok(sm2))
               st_in = svie_pkg::ST_BAD_MEM;
            else begin r_in = b_ff; nsp_in = sm1; nip_in = ipn; end
         end
         svie_pkg::OP_STORE8: begin
            if (!word_ok(sm1) || a_ff >= 32'(ByteLimit) || !word_ok(sm2))
               st_in = svie_pkg::ST_BAD_MEM;
            else if (b_ff > svie_pkg::BYTE_MASK) st_in = svie_pkg::ST_BAD_SIZE;
            else begin
               r_in   = (c_ff & ~(svie_pkg::BYTE_MASK << sh)) | (b_ff << sh);
               nsp_in = sm1; nip_in = ipn;
            end
         end
         svie_pkg::OP_GOTO, svie_pkg::OP_LABEL: nip_in = pv_ff;
         svie_pkg::OP_CALL: begin
            if (!word_ok(sp3) || !word_ok(sp_ff)) st_in = svie_pkg::ST_BAD_MEM;
            else begin
               r_in = ipn; nip_in = pv_ff; nsp_in = sp3; nfp_in = sp3;
            end
         end
         svie_pkg::OP_RETURN: begin
            if (!word_ok(fm3) || !word_ok(fm1)) st_in = svie_pkg::ST_BAD_MEM;
            else begin nip_in = a_ff; nfp_in = b_ff; nsp_in = c_ff; end
         end
         svie_pkg::OP_LEAVE: begin
            if (!word_ok(fm1)) st_in = svie_pkg::ST_BAD_MEM;
            else begin nfp_in = a_ff; nsp_in = fm1; nip_in = ipn; end
         end
         svie_pkg::OP_JUMPZ, svie_pkg::OP_JUMPNZ: begin
            if (!word_ok(sm1)) st_in = svie_pkg::ST_BAD_MEM;
            else begin
               nip_in = ((kind_ff == svie_pkg::OP_JUMPNZ) == (a_ff != 32'd0)) ? pv_ff : ipn;
               nsp_in = sm1;
            end
         end
         svie_pkg::OP_DUP: begin
            if (!word_ok(sm1) || !word_ok(sp_ff)) st_in = svie_pkg::ST_BAD_MEM;
            else begin r_in = a_ff; nsp_in = sp1; nip_in = ipn; end
         end
         svie_pkg::OP_HALT: st_in = svie_pkg::ST_HALTED;
         svie_pkg::OP_NOOP: nip_in = ipn;
         default:           st_in = svie_pkg::ST_ILLEGAL;
      endcase
   end

   // One quotient bit per cycle on the magnitudes.
   assign dsh = {rem_ff, quo_ff[31]};
   assign dge = dsh >= {1'b0, dvs_ff};

   always_ff @(posedge clock) begin
      if (cmd.clear_wr)      mem[clr_ff]  <= 32'd0;
      else if (cmd.alloc_wr) mem[acnt_ff] <= 32'd0;
      else if (cmd.wr_en)    mem[wr_addr] <= wr_data;
      if (cmd.rd_issue) rdata_ff <= mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sp_ff  <= 32'd0;
         fp_ff  <= 32'd0;
         ip_ff  <= 32'd0;
         clr_ff <= '0;
      end else begin
         if (cmd.clear_wr) clr_ff <= clr_ff + AW'(1);
         if (cmd.finish) begin
            sp_ff <= nsp_ff;
            fp_ff <= nfp_ff;
            ip_ff <= nip_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         kind_ff  <= req_kind;
         ptype_ff <= req_param_type;
         pv_ff    <= req_param_value;
         sel_ff   <= req_reg_select;
      end
      if (cmd.rd_capture) begin
         case (cmd.idx)
            2'd0:    a_ff <= rdata_ff;
            2'd1:    b_ff <= rdata_ff;
            default: c_ff <= rdata_ff;
         endcase
      end
      if (cmd.exec) begin
         st_ff   <= st_in;
         nsp_ff  <= nsp_in;
         nfp_ff  <= nfp_in;
         nip_ff  <= nip_in;
         r_ff    <= r_in;
         acnt_ff <= start[AW-1:0];
         aend_ff <= top[AW-1:0];
         rem_ff  <= 32'd0;
         quo_ff  <= a_ff[31] ? -a_ff : a_ff;
         dvs_ff  <= b_ff[31] ? -b_ff : b_ff;
         neg_ff  <= a_ff[31] ^ b_ff[31];
         dcnt_ff <= 5'd0;
      end
      if (cmd.div_step) begin
         rem_ff  <= dge ? 32'(dsh - {1'b0, dvs_ff}) : dsh[31:0];
         quo_ff  <= {quo_ff[30:0], dge};
         dcnt_ff <= dcnt_ff + 5'd1;
      end
      if (cmd.div_fix) r_ff <= neg_ff ? -quo_ff : quo_ff;
      if (cmd.alloc_wr) acnt_ff <= acnt_ff + AW'(1);
      if (cmd.finish) begin
         rsp_status_ff <= st_ff;
         rsp_ip_ff     <= nip_ff;
         rsp_sp_ff     <= nsp_ff;
         rsp_fp_ff     <= nfp_ff;
      end
   end

   assign stat.rd_count   = svie_pkg::num_reads(kind_ff);
   assign stat.wr_count   = svie_pkg::num_writes(kind_ff);
   assign stat.fault      = st_in != svie_pkg::ST_OK;
   assign stat.is_div     = kind_ff == svie_pkg::OP_DIV && st_in == svie_pkg::ST_OK;
   assign stat.div_last   = dcnt_ff == 5'd31;
   assign stat.alloc_any  = alloc_any;
   assign stat.alloc_last = acnt_ff + AW'(1) == aend_ff;
   assign stat.clear_last = clr_ff == AW'(Words - 1);

   assign rsp_status        = rsp_status_ff;
   assign rsp_next_ip       = rsp_ip_ff;
   assign rsp_stack_ptr_out = rsp_sp_ff;
   assign rsp_frame_ptr_out = rsp_fp_ff;

endmodule
